>>> hw/rtl/ring_neighbor_resource_arbiter_macros.svh
// Assertion macros used by the checker file of the ring arbiter.
`ifndef RING_NEIGHBOR_RESOURCE_ARBITER_MACROS_SVH
`define RING_NEIGHBOR_RESOURCE_ARBITER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RNRA_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ring arbiter check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RNRA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ring arbiter check failed: next-cycle implication");

`endif

>>> hw/rtl/rnra_pkg.sv
// Types and constants shared by the ring neighbor resource arbiter modules.
`default_nettype none

package rnra_pkg;

    // Fixed field widths of the stream and configuration payloads.
    localparam int AGENT_W = 6;
    localparam int CFG_W   = 7;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // Operation codes carried on the input tuser bit.
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Reset value of the ring size register.
    localparam logic [CFG_W-1:0] NUM_AGENTS_RESET = 7'd5;

    // State of one agent in the ring.
    typedef enum logic [1:0] {
        AG_THINKING = 2'd0,
        AG_HUNGRY   = 2'd1,
        AG_EATING   = 2'd2
    } agent_state_t;

    // Address source for the state memory read port.
    typedef enum logic [1:0] {
        SEL_AGENT     = 2'd0,
        SEL_TGT       = 2'd1,
        SEL_TGT_LEFT  = 2'd2,
        SEL_TGT_RIGHT = 2'd3
    } rd_sel_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_SELF,
        ST_CHECK_SELF,
        ST_READ_TGT,
        ST_READ_LEFT,
        ST_READ_RIGHT,
        ST_DECIDE,
        ST_FINISH
    } fsm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_in;
        rd_sel_t rd_sel;
        logic    flag_err;
        logic    wr_self;
        logic    latch_x;
        logic    latch_l;
        logic    decide;
        logic    load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic oob;
        logic self_ok;
        logic more_test;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/ring_neighbor_resource_arbiter.sv
// Top level of the ring neighbor resource arbiter.
//
// Agents sit in a ring; each is thinking, hungry or eating. An input beat is a
// request (tuser 0) or a release (tuser 1) from one agent. A request makes the
// agent hungry and grants it when neither neighbor eats; a release makes it
// thinking and retests the left, then the right neighbor.
// Each input beat yields exactly one output beat with the grants, the neighbor
// indices and an error flag; errored beats change no state.
// The cfg channel writes the ring size and is always ready; the user must write it
// only while the block holds no item in flight, as the block does not enforce it.
// One item at a time: an out-of-range agent ends after the own-state read, an
// illegal operation after the own-state check, a request after testing the agent
// itself and a release after testing both neighbors; the next beat is taken once
// the sequencer is back in idle. Each state lookup is a separate read of the
// single read port of the agent state memory, which has registered read data.
// Reset clears all agents to thinking through per-entry valid bits and sets
// the ring size to five; no clearing pass is needed.
// A stalled receiver holds the output beat; the next item is still accepted
// and worked on, and waits for the output register before it is shown.
`default_nettype none

module ring_neighbor_resource_arbiter
    import rnra_pkg::*;
#(
    parameter int MAX_AGENTS = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_W-1:0]      cfg_data,      // num_agents
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [5:0] agent, [7:6] zero
    input  wire logic [0:0]            s_axis_tuser,  // [0] operation
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata   // [0] grant_self, [1] grant_left,
                                                      // [2] grant_right, [8:3] left_agent,
                                                      // [14:9] right_agent, [15] error
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    rnra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // State memory and result datapath.
    rnra_datapath #(
        .MAX_AGENTS (MAX_AGENTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_op     (s_axis_tuser[0]),
        .in_agent  (s_axis_tdata[AGENT_W-1:0]),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/rnra_ctrl.sv
// Sequencer that steps one request or release through the state memory.
`default_nettype none

module rnra_ctrl
    import rnra_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output register can take a new beat when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // State register and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ_SELF;
                end
            end
            ST_READ_SELF:
            begin
                state_next = status.oob ? ST_FINISH : ST_CHECK_SELF;
            end
            ST_CHECK_SELF:
            begin
                state_next = status.self_ok ? ST_READ_TGT : ST_FINISH;
            end
            ST_READ_TGT:
            begin
                state_next = ST_READ_LEFT;
            end
            ST_READ_LEFT:
            begin
                state_next = ST_READ_RIGHT;
            end
            ST_READ_RIGHT:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = status.more_test ? ST_READ_TGT : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands for the current state.
    always_comb
    begin
        cmd      = '0;
        cmd.rd_sel = SEL_AGENT;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_READ_SELF:
            begin
                cmd.rd_sel   = SEL_AGENT;
                cmd.flag_err = status.oob;
            end
            ST_CHECK_SELF:
            begin
                cmd.wr_self  = status.self_ok;
                cmd.flag_err = !status.self_ok;
            end
            ST_READ_TGT:
            begin
                cmd.rd_sel = SEL_TGT;
            end
            ST_READ_LEFT:
            begin
                cmd.latch_x = 1'b1;
                cmd.rd_sel  = SEL_TGT_LEFT;
            end
            ST_READ_RIGHT:
            begin
                cmd.latch_l = 1'b1;
                cmd.rd_sel  = SEL_TGT_RIGHT;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd.rd_sel = SEL_AGENT;
            end
        endcase
    end

    // Output valid sets on a load and clears when the beat is taken.
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rnra_datapath.sv
// Datapath: ring size register, agent state memory, neighbor math and result registers.
`default_nettype none

module rnra_datapath
    import rnra_pkg::*;
#(
    parameter int MAX_AGENTS = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               in_op,
    input  wire logic [AGENT_W-1:0] in_agent,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              status,
    output logic [OUT_DATA_W-1:0]   out_data
);

    localparam int IDX_W = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int CW    = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
    localparam logic [CW-1:0] RING_MIN = CW'(2);
    localparam logic [CW-1:0] RING_MAX = CW'(MAX_AGENTS);

    logic [CFG_W-1:0]   num_agents_reg;
    logic               op_reg;
    logic [AGENT_W-1:0] agent_reg;
    logic [IDX_W-1:0]   tgt_reg;
    logic [IDX_W-1:0]   tgt_next;
    logic               test_idx_reg;
    agent_state_t       x_st_reg;
    agent_state_t       l_st_reg;
    logic               gs_reg;
    logic               gl_reg;
    logic               gr_reg;
    logic               err_reg;

    agent_state_t       state_ram [MAX_AGENTS];
    logic [MAX_AGENTS-1:0] vld_reg;
    agent_state_t       rd_data_reg;
    logic               rd_vld_reg;
    agent_state_t       rd_st;

    logic [CW-1:0]      ring_n;
    logic [CW-1:0]      ring_last;
    logic [IDX_W-1:0]   agent_idx;
    logic [IDX_W-1:0]   left_a;
    logic [IDX_W-1:0]   right_a;
    logic [IDX_W-1:0]   left_t;
    logic [IDX_W-1:0]   right_t;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    agent_state_t       wr_data;
    logic               grant;

    logic [AGENT_W-1:0] out_la_reg;
    logic [AGENT_W-1:0] out_ra_reg;
    logic               out_gs_reg;
    logic               out_gl_reg;
    logic               out_gr_reg;
    logic               out_err_reg;

    // Configuration is always accepted; the user must write it only while idle, as the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_agents_reg <= NUM_AGENTS_RESET;
        end
        else if (cfg_valid)
        begin
            num_agents_reg <= cfg_data;
        end
    end

    // Effective ring size, saturated to the supported range.
    always_comb
    begin
        ring_n = CW'(num_agents_reg);
        if (ring_n < RING_MIN)
        begin
            ring_n = RING_MIN;
        end
        else if (ring_n > RING_MAX)
        begin
            ring_n = RING_MAX;
        end
        ring_last = ring_n - CW'(1);
    end

    // Neighbor indices of the issuing agent and of the agent under test.
    assign agent_idx = IDX_W'(agent_reg);
    assign left_a  = (agent_idx == '0) ? IDX_W'(ring_last) : agent_idx - IDX_W'(1);
    assign right_a = (CW'(agent_idx) == ring_last) ? '0 : agent_idx + IDX_W'(1);
    assign left_t  = (tgt_reg == '0) ? IDX_W'(ring_last) : tgt_reg - IDX_W'(1);
    assign right_t = (CW'(tgt_reg) == ring_last) ? '0 : tgt_reg + IDX_W'(1);

    // Read address selection.
    always_comb
    begin
        unique case (cmd.rd_sel)
            SEL_AGENT:     rd_addr = agent_idx;
            SEL_TGT:       rd_addr = tgt_reg;
            SEL_TGT_LEFT:  rd_addr = left_t;
            SEL_TGT_RIGHT: rd_addr = right_t;
            default:       rd_addr = agent_idx;
        endcase
    end

    // Entries never written read as thinking.
    assign rd_st = rd_vld_reg ? rd_data_reg : AG_THINKING;

    // Status toward the controller.
    assign status.oob       = CW'(agent_reg) >= ring_n;
    assign status.self_ok   = (op_reg == OP_REQUEST) ? (rd_st == AG_THINKING)
                                                     : (rd_st == AG_EATING);
    assign status.more_test = (op_reg == OP_RELEASE) && !test_idx_reg;

    // A hungry agent with no eating neighbor starts eating.
    assign grant = (x_st_reg == AG_HUNGRY) && (l_st_reg != AG_EATING) &&
                   (rd_st != AG_EATING);

    // Single write port: own state update, or a grant to the agent under test.
    always_comb
    begin
        wr_en   = cmd.wr_self || (cmd.decide && grant);
        wr_addr = cmd.wr_self ? agent_idx : tgt_reg;
        if (cmd.wr_self)
        begin
            wr_data = (op_reg == OP_REQUEST) ? AG_HUNGRY : AG_THINKING;
        end
        else
        begin
            wr_data = AG_EATING;
        end
    end

    // State memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_ram[wr_addr] <= wr_data;
        end
        rd_data_reg <= state_ram[rd_addr];
    end

    // Per-entry valid bits stand in for the all-thinking reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // Next agent under test.
    always_comb
    begin
        tgt_next = tgt_reg;
        if (cmd.wr_self)
        begin
            tgt_next = (op_reg == OP_REQUEST) ? agent_idx : left_a;
        end
        else if (cmd.decide)
        begin
            tgt_next = right_a;
        end
    end

    // Item, test and result registers.
    always_ff @(posedge clk)
    begin
        tgt_reg <= tgt_next;
        if (cmd.load_in)
        begin
            op_reg    <= in_op;
            agent_reg <= in_agent;
            gs_reg    <= 1'b0;
            gl_reg    <= 1'b0;
            gr_reg    <= 1'b0;
            err_reg   <= 1'b0;
        end
        if (cmd.flag_err)
        begin
            err_reg <= 1'b1;
        end
        if (cmd.wr_self)
        begin
            test_idx_reg <= 1'b0;
        end
        if (cmd.latch_x)
        begin
            x_st_reg <= rd_st;
        end
        if (cmd.latch_l)
        begin
            l_st_reg <= rd_st;
        end
        if (cmd.decide)
        begin
            test_idx_reg <= 1'b1;
            if (op_reg == OP_REQUEST)
            begin
                gs_reg <= grant;
            end
            else if (!test_idx_reg)
            begin
                gl_reg <= grant;
            end
            else
            begin
                gr_reg <= grant;
            end
        end
    end

    // Output register, parted from the working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_gs_reg  <= gs_reg;
            out_gl_reg  <= gl_reg;
            out_gr_reg  <= gr_reg;
            out_err_reg <= err_reg;
            out_la_reg  <= status.oob ? '0 : AGENT_W'(left_a);
            out_ra_reg  <= status.oob ? '0 : AGENT_W'(right_a);
        end
    end

    assign out_data = {out_err_reg, out_ra_reg, out_la_reg, out_gr_reg, out_gl_reg,
                       out_gs_reg};

endmodule

`default_nettype wire

>>> hw/rtl/rnra_checker.sv
// Port-level checks of the ring arbiter, bound to its top level.
`default_nettype none
`include "ring_neighbor_resource_arbiter_macros.svh"

module rnra_checker
    import rnra_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // A stalled output beat stays valid and unchanged.
    `RNRA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // One item at a time: input is not ready right after a beat is taken.
    `RNRA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A rejected item grants nothing.
    `RNRA_ASSERT_IMPLY(a_err_no_grant, clk, rst_n, m_axis_tvalid && m_axis_tdata[15], m_axis_tdata[2:0] == 3'b000)

    // A request grant never comes with a release grant.
    `RNRA_ASSERT_IMPLY(a_grant_kind, clk, rst_n, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[1] && !m_axis_tdata[2])

endmodule

bind ring_neighbor_resource_arbiter rnra_checker u_rnra_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
